FILE: rtl/bipolar_full_step_sequencer_defines.svh
// Assertion macros used by the checker file.
`ifndef BIPOLAR_FULL_STEP_SEQUENCER_DEFINES_SVH
`define BIPOLAR_FULL_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BFS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bfs assertion failed");

// Next-cycle implication, disabled during reset.
`define BFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bfs assertion failed");

`endif

FILE: rtl/bfs_pkg.sv
package bfs_pkg;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_CMD      = 2'd1,
    MODE_FAILSAFE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    MOVE_STOP = 2'd0,
    MOVE_FWD  = 2'd1,
    MOVE_REV  = 2'd2
  } move_e;

  typedef enum logic [1:0] {
    DRV_COAST = 2'd0,
    DRV_FWD   = 2'd1,
    DRV_REV   = 2'd2
  } drv_e;

  typedef enum logic [2:0] {
    CFG_DRV_EN   = 3'd0,
    CFG_UNIDIR   = 3'd1,
    CFG_PHASE_RV = 3'd2,
    CFG_PERIOD   = 3'd3,
    CFG_DUTY     = 3'd4
  } cfg_idx_e;

  localparam logic [1:0]  PHASE_MASK     = 2'h3;
  localparam logic [6:0]  DUTY_MAX       = 7'd100;
  localparam logic [6:0]  DUTY_RESET     = 7'd50;
  localparam logic [31:0] PERIOD_RESET   = 32'd2000;
  localparam int unsigned IN_TDATA_BITS  = 40;
  localparam int unsigned OUT_TDATA_BITS = 16;

  // Result fields, bridge A in the lowest bits.
  typedef struct packed {
    logic       running_now;
    logic       stepped;
    logic [6:0] duty_percent;
    drv_e       coil_b_drive;
    drv_e       coil_a_drive;
  } result_t;

  // Two-phase-on full-step table.
  function automatic drv_e phase_a(input logic [1:0] p);
    drv_e d;
    case (p)
      2'd0:    d = DRV_FWD;
      2'd1:    d = DRV_REV;
      2'd2:    d = DRV_REV;
      default: d = DRV_FWD;
    endcase
    return d;
  endfunction

  function automatic drv_e phase_b(input logic [1:0] p);
    drv_e d;
    case (p)
      2'd0:    d = DRV_FWD;
      2'd1:    d = DRV_FWD;
      2'd2:    d = DRV_REV;
      default: d = DRV_REV;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/bipolar_full_step_sequencer.sv
// Full-step sequencer for a two-phase bipolar stepper on two H-bridges.
// Slave stream: tuser = mode (tick, move command, failsafe); tdata = move in
//   bits [1:0], now_us in bits [33:2]. Every transaction yields one result.
// Master stream: tdata = bridge A, bridge B, duty, stepped, running flag.
// Config channel: cfg_index_i selects a register, cfg_data_i carries the
//   value; always ready. Write it only while the block is idle.
// Pipeline: an item taken from the slave stream sits in the input register, and its
//   result moves into the output register when that register advances.
// Throughput: one item per cycle unless the output stalls; between the registers
//   an item needs a TIME_BITS-wide subtract, a 2-bit phase step and a TIME_BITS-wide add.
// Stall: the output register holds its result while m_axis_tready_i is low; the
//   input register takes one more transaction if it is empty, then tready drops.
// Reset: both bridges coast, stepper stopped, phase 0, due time 0, and the
//   registers return to enabled, bidirectional, normal order, 2000 us, 50 %.
module bipolar_full_step_sequencer
  import bfs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,  // move[1:0], now_us[33:2], zero pad
  input  logic [1:0]                s_axis_tuser_i,  // mode[1:0]
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o,  // a[1:0], b[3:2], duty[10:4],
                                                     // stepped[11], running[12], zero pad
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i
);

  typedef logic [TIME_BITS-1:0] time_t;

  logic        cfg_en_q, cfg_unidir_q, cfg_phrv_q;
  logic [31:0] cfg_period_q;
  logic [6:0]  cfg_duty_q;

  logic        in_valid_q;
  logic [1:0]  in_mode_q, in_move_q;
  logic [31:0] in_now_q;

  logic        running_q, running_d;
  logic        rev_q, rev_d;
  logic [1:0]  phase_q, phase_d;
  time_t       due_q, due_d;
  drv_e        bra_q, bra_d, brb_q, brb_d;

  logic        out_valid_q;
  result_t     out_q, out_d;

  logic        adv;
  logic        stepped;
  time_t       now_t, diff;
  logic        rev_req, back;
  logic [6:0]  duty_sat;

  assign cfg_ready_o     = 1'b1;
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || adv;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_BITS - $bits(result_t))'(0), out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_en_q     <= 1'b1;
      cfg_unidir_q <= 1'b0;
      cfg_phrv_q   <= 1'b0;
      cfg_period_q <= PERIOD_RESET;
      cfg_duty_q   <= DUTY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DRV_EN:   cfg_en_q     <= cfg_data_i[0];
        CFG_UNIDIR:   cfg_unidir_q <= cfg_data_i[0];
        CFG_PHASE_RV: cfg_phrv_q   <= cfg_data_i[0];
        CFG_PERIOD:   cfg_period_q <= cfg_data_i;
        CFG_DUTY:     cfg_duty_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_mode_q <= s_axis_tuser_i;
      in_move_q <= s_axis_tdata_i[1:0];
      in_now_q  <= s_axis_tdata_i[33:2];
    end
  end

  assign now_t    = TIME_BITS'(in_now_q);
  assign diff     = now_t - due_q;
  assign rev_req  = (move_e'(in_move_q) == MOVE_REV);
  assign back     = rev_q ^ cfg_phrv_q;
  assign duty_sat = (cfg_duty_q > DUTY_MAX) ? DUTY_MAX : cfg_duty_q;

  always_comb begin
    running_d = running_q;
    rev_d     = rev_q;
    phase_d   = phase_q;
    due_d     = due_q;
    bra_d     = bra_q;
    brb_d     = brb_q;
    stepped   = 1'b0;
    case (mode_e'(in_mode_q))
      MODE_CMD: begin
        if (!(move_e'(in_move_q) == MOVE_FWD || rev_req) || !cfg_en_q ||
            (rev_req && cfg_unidir_q)) begin
          running_d = 1'b0;
          rev_d     = 1'b0;
          bra_d     = DRV_COAST;
          brb_d     = DRV_COAST;
        end else begin
          if (!running_q || (rev_q != rev_req)) begin
            due_d = now_t;
          end
          running_d = 1'b1;
          rev_d     = rev_req;
        end
      end
      MODE_FAILSAFE: begin
        running_d = 1'b0;
        rev_d     = 1'b0;
        bra_d     = DRV_COAST;
        brb_d     = DRV_COAST;
      end
      MODE_TICK: begin
        if (running_q && cfg_en_q && !diff[TIME_BITS-1]) begin
          bra_d   = phase_a(phase_q);
          brb_d   = phase_b(phase_q);
          phase_d = back ? ((phase_q - 2'd1) & PHASE_MASK)
                         : ((phase_q + 2'd1) & PHASE_MASK);
          due_d   = now_t + TIME_BITS'(cfg_period_q);
          stepped = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d.coil_a_drive = bra_d;
    out_d.coil_b_drive = brb_d;
    out_d.duty_percent = (bra_d == DRV_COAST && brb_d == DRV_COAST) ? 7'd0 : duty_sat;
    out_d.stepped      = stepped;
    out_d.running_now  = running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      rev_q       <= 1'b0;
      phase_q     <= 2'd0;
      due_q       <= '0;
      bra_q       <= DRV_COAST;
      brb_q       <= DRV_COAST;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        running_q <= running_d;
        rev_q     <= rev_d;
        phase_q   <= phase_d;
        due_q     <= due_d;
        bra_q     <= bra_d;
        brb_q     <= brb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: rtl/bfs_checker.sv
`include "bipolar_full_step_sequencer_defines.svh"

module bfs_checker
  import bfs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  result_t res;
  assign res = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);

  // stalled result must hold
  `BFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // with no result pending the input side must be open
  `BFS_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)

  // duty only when a bridge is energised, and never above full scale
  `BFS_ASSERT_IMPL(a_duty_coast, clk_i, rst_ni,
                   m_axis_tvalid_o && res.coil_a_drive == DRV_COAST &&
                   res.coil_b_drive == DRV_COAST, res.duty_percent == 7'd0)
  `BFS_ASSERT_IMPL(a_duty_max, clk_i, rst_ni, m_axis_tvalid_o,
                   res.duty_percent <= DUTY_MAX)

  // a commutation drives both bridges while running
  `BFS_ASSERT_IMPL(a_step_drive, clk_i, rst_ni, m_axis_tvalid_o && res.stepped,
                   res.running_now && res.coil_a_drive != DRV_COAST &&
                   res.coil_b_drive != DRV_COAST)

endmodule

bind bipolar_full_step_sequencer bfs_checker u_bfs_checker (.*);

FILE: tb/tb_bipolar_full_step_sequencer.sv
module tb_bipolar_full_step_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import bfs_pkg::*;

  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [1:0] MOVE_SPARE   = 2'd3;
  localparam logic [2:0] CFG_SPARE    = 3'd5;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         SETTLE_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  bipolar_full_step_sequencer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Register copies
  logic        cfg_enable   = 1'b1;
  logic        cfg_unidir   = 1'b0;
  logic        cfg_phase_rv = 1'b0;
  logic [31:0] cfg_period   = PERIOD_RESET;
  logic [6:0]  cfg_duty     = DUTY_RESET;

  // Sequencer state copies
  logic        run_q   = 1'b0;
  logic        rev_q   = 1'b0;
  logic [1:0]  phase_q = 2'd0;
  logic [31:0] due_q   = 32'd0;
  drv_e        drv_a_q = DRV_COAST;
  drv_e        drv_b_q = DRV_COAST;

  result_t     expected_drives[$];
  int          err_count     = 0;
  int          results_seen  = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic [31:0] sim_us        = 32'd0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_drives.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, tdata 0x%h", m_axis_tdata_o));
      end else begin
        want = expected_drives.pop_front();
        got  = result_t'(m_axis_tdata_o[12:0]);
        check_field("coil_a", got.coil_a_drive, want.coil_a_drive);
        check_field("coil_b", got.coil_b_drive, want.coil_b_drive);
        check_field("duty", got.duty_percent, want.duty_percent);
        check_field("stepped", got.stepped, want.stepped);
        check_field("running", got.running_now, want.running_now);
      end
      results_seen++;
    end
  end

  function automatic void coast_bridges();
    run_q   = 1'b0;
    rev_q   = 1'b0;
    drv_a_q = DRV_COAST;
    drv_b_q = DRV_COAST;
  endfunction

  function automatic result_t advance_sequencer(input logic [1:0] mode, input logic [1:0] move,
                                                input logic [31:0] now_us);
    result_t     r;
    logic [31:0] lag;
    logic        stepped;
    logic        back;
    logic [6:0]  duty;
    stepped = 1'b0;
    if (mode == MODE_CMD) begin
      if ((move != MOVE_FWD && move != MOVE_REV) || !cfg_enable ||
          (move == MOVE_REV && cfg_unidir)) begin
        coast_bridges();
      end else begin
        if (!run_q || rev_q != (move == MOVE_REV)) due_q = now_us;
        run_q = 1'b1;
        rev_q = (move == MOVE_REV);
      end
    end else if (mode == MODE_FAILSAFE) begin
      coast_bridges();
    end else if (mode == MODE_TICK && run_q && cfg_enable) begin
      lag = now_us - due_q;
      if (!lag[31]) begin
        case (phase_q)
          2'd0: begin
            drv_a_q = DRV_FWD;
            drv_b_q = DRV_FWD;
          end
          2'd1: begin
            drv_a_q = DRV_REV;
            drv_b_q = DRV_FWD;
          end
          2'd2: begin
            drv_a_q = DRV_REV;
            drv_b_q = DRV_REV;
          end
          default: begin
            drv_a_q = DRV_FWD;
            drv_b_q = DRV_REV;
          end
        endcase
        back    = rev_q ^ cfg_phase_rv;
        phase_q = back ? phase_q - 2'd1 : phase_q + 2'd1;
        due_q   = now_us + cfg_period;
        stepped = 1'b1;
      end
    end
    duty = (cfg_duty > DUTY_MAX) ? DUTY_MAX : cfg_duty;
    if (drv_a_q == DRV_COAST && drv_b_q == DRV_COAST) duty = '0;
    r.coil_a_drive = drv_a_q;
    r.coil_b_drive = drv_b_q;
    r.duty_percent = duty;
    r.stepped      = stepped;
    r.running_now  = run_q;
    return r;
  endfunction

  // Leaves tvalid high after the transaction; the next call or drain() decides.
  task automatic send_item(input logic [1:0] mode, input logic [1:0] move,
                           input logic [31:0] now_us);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, now_us, move};
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_drives.push_back(advance_sequencer(mode, move, now_us));
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
  endtask

  // hold keeps cfg_valid_i high for a following write.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val, input bit hold);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DRV_EN:   cfg_enable   = val[0];
      CFG_UNIDIR:   cfg_unidir   = val[0];
      CFG_PHASE_RV: cfg_phase_rv = val[0];
      CFG_PERIOD:   cfg_period   = val;
      CFG_DUTY:     cfg_duty     = val[6:0];
      default: ;
    endcase
    if (!hold) cfg_valid_i <= 1'b0;
  endtask

  task automatic randomize_config();
    logic [31:0] period;
    logic [31:0] duty;
    int          sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       period = 32'd0;
      1:       period = 32'd1;
      2:       period = 32'hFFFF_FFFF;
      3:       period = $urandom;
      default: period = $urandom_range(2, 64);
    endcase
    sel = $urandom_range(0, 5);
    case (sel)
      0:       duty = 32'd0;
      1:       duty = DUTY_MAX;
      2:       duty = 32'd127;
      default: duty = $urandom_range(0, 127);
    endcase
    // upper data bits are don't-care for the flag registers
    write_reg(CFG_DRV_EN, {$urandom, 1'b0} | ($urandom_range(0, 99) < 85), 1'b1);
    write_reg(CFG_UNIDIR, $urandom, 1'b1);
    write_reg(CFG_PHASE_RV, $urandom, 1'b1);
    write_reg(CFG_PERIOD, period, 1'b1);
    write_reg(CFG_DUTY, {$urandom, 7'd0} | duty, 1'b0);
  endtask

  task automatic run_segment(input int items);
    int          sent;
    int          sel;
    int          span;
    logic [1:0]  mode;
    logic [1:0]  move;
    logic [31:0] now_us;
    sent = 0;
    while (sent < items) begin
      sel  = $urandom_range(0, 99);
      mode = MODE_TICK;
      move = 2'($urandom);
      span = (cfg_period > 200) ? 200 : int'(cfg_period);
      if (sel < 60) begin
        sim_us += $urandom_range(0, 2 * span + 1);
        now_us = sim_us;
      end else if (sel < 74) begin
        // just before, at or just after the due time
        sim_us = due_q + $urandom_range(0, 2) - 1;
        now_us = sim_us;
      end else if (sel < 78) begin
        now_us = $urandom;
      end else if (sel < 94) begin
        mode = MODE_CMD;
        sel  = $urandom_range(0, 99);
        move = (sel < 45) ? MOVE_FWD : (sel < 88) ? MOVE_REV : (sel < 96) ? MOVE_STOP : MOVE_SPARE;
        now_us = sim_us;
      end else if (sel < 97) begin
        mode   = MODE_FAILSAFE;
        now_us = $urandom;
      end else begin
        mode   = MODE_SPARE;
        now_us = $urandom;
      end
      send_item(mode, move, now_us);
      if (mode != MODE_SPARE) sent++;
    end
  endtask

  task automatic run_phase(input int send_pct, input int stall_in);
    send_idle_pct = send_pct;
    stall_pct     = stall_in;
    repeat (2) begin
      drain();
      randomize_config();
      run_segment(105);
    end
  endtask

  task automatic test_idle_and_spare_codes();
    send_item(MODE_TICK, MOVE_STOP, 32'd0);
    send_item(MODE_SPARE, MOVE_REV, 32'hFFFF_FFFF);
    send_item(MODE_CMD, MOVE_STOP, 32'h0000_0010);
    send_item(MODE_CMD, MOVE_SPARE, 32'h0000_0020);
    send_item(MODE_FAILSAFE, MOVE_FWD, 32'h0000_0030);
  endtask

  task automatic test_commutation_and_wrap();
    send_item(MODE_CMD, MOVE_FWD, 32'hFFFF_FFF0);
    send_item(MODE_TICK, MOVE_STOP, 32'hFFFF_FFF0);
    send_item(MODE_TICK, MOVE_STOP, 32'h0000_07BF);
    send_item(MODE_TICK, MOVE_STOP, 32'h0000_07C0);
    send_item(MODE_CMD, MOVE_FWD, 32'h0000_07C1);
    send_item(MODE_CMD, MOVE_REV, 32'h0000_0800);
    send_item(MODE_TICK, MOVE_STOP, 32'h0000_0800);
    send_item(MODE_TICK, MOVE_STOP, 32'h0000_0FCF);
    send_item(MODE_FAILSAFE, MOVE_STOP, 32'h0000_0FD0);
  endtask

  task automatic test_driver_disable();
    send_item(MODE_CMD, MOVE_FWD, 32'h0000_1000);
    send_item(MODE_TICK, MOVE_STOP, 32'h0000_1000);
    drain();
    write_reg(CFG_DRV_EN, 32'd0, 1'b0);
    send_item(MODE_TICK, MOVE_STOP, 32'h0000_5000);
    send_item(MODE_CMD, MOVE_FWD, 32'h0000_5001);
  endtask

  task automatic test_unidirectional();
    drain();
    write_reg(CFG_DRV_EN, 32'd1, 1'b1);
    write_reg(CFG_UNIDIR, 32'd1, 1'b0);
    send_item(MODE_CMD, MOVE_REV, 32'h0000_6000);
    send_item(MODE_CMD, MOVE_FWD, 32'h0000_6001);
  endtask

  task automatic test_phase_order_and_extremes();
    drain();
    write_reg(CFG_PHASE_RV, 32'd1, 1'b1);
    write_reg(CFG_PERIOD, 32'd0, 1'b1);
    write_reg(CFG_DUTY, 32'd127, 1'b0);
    repeat (3) send_item(MODE_TICK, MOVE_STOP, 32'h0000_9000);
    drain();
    write_reg(CFG_DUTY, 32'd0, 1'b1);
    write_reg(CFG_PERIOD, 32'hFFFF_FFFF, 1'b1);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF, 1'b0);
    repeat (2) send_item(MODE_TICK, MOVE_STOP, 32'h0000_9001);
  endtask

  task automatic test_random_traffic();
    sim_us = $urandom;
    run_phase(0, 0);
    run_phase(54, 0);
    run_phase(0, 54);
    run_phase(11, 11);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_spare_codes();
    test_commutation_and_wrap();
    test_driver_disable();
    test_unidirectional();
    test_phase_order_and_extremes();
    test_random_traffic();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && expected_drives.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_count, expected_drives.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
